// ===== rtl/srv_pkg.sv =====
// Shared constants, result type and CRC32 byte update for the slot record validator.
package srv_pkg;

	localparam int HDR_BYTES = 20;
	localparam int TRL_BYTES = 4;
	localparam int MAGIC_END = 4;
	localparam int VER_POS   = 4;
	localparam int RSV_END   = 8;
	localparam int GEN_END   = 16;

	localparam logic [7:0]  VERSION_ONE = 8'h01;
	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

	localparam int OUT_W  = 104;
	localparam int IN_W   = 8;

	typedef logic [3:0] status_t;

	localparam status_t ST_OK       = 4'd0;
	localparam status_t ST_SHORT    = 4'd1;
	localparam status_t ST_MAGIC    = 4'd2;
	localparam status_t ST_VERSION  = 4'd3;
	localparam status_t ST_RESERVED = 4'd4;
	localparam status_t ST_ZERO_GEN = 4'd5;
	localparam status_t ST_LENGTH   = 4'd6;
	localparam status_t ST_CRC      = 4'd7;
	localparam status_t ST_TOO_LONG = 4'd8;

	typedef struct packed {
		logic [31:0] body_len;
		logic [63:0] generation;
		status_t     status;
		logic        record_valid;
	} result_t;

	// One byte of the reflected IEEE CRC32, bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== rtl/srv_core.sv =====
// Per-record state of the validator: header capture, running CRC and final verdict.
module srv_core #(
	parameter int MAX_RECORD_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [31:0]       magic_word,
	output srv_pkg::result_t  result
);
	import srv_pkg::*;

	localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORD_BYTES);

	logic [CNT_W-1:0] count_q, count_d;
	logic             too_long_q, too_long_d;
	logic [2:0]       hdr_err_q, hdr_err_d;
	logic [31:0]      crc_q, crc_d;
	logic [63:0]      gen_q, gen_d;
	logic [31:0]      len_q, len_d;
	logic [31:0]      trailer_q, trailer_d;

	logic [7:0]       magic_byte;
	logic [32:0]      len_sum;
	logic [31:0]      crc_final;
	status_t          status;

	always_comb begin
		unique case (count_q[1:0])
			2'd0: magic_byte = magic_word[31:24];
			2'd1: magic_byte = magic_word[23:16];
			2'd2: magic_byte = magic_word[15:8];
			default: magic_byte = magic_word[7:0];
		endcase
	end

	// State after absorbing the current byte.
	always_comb begin
		count_d    = count_q;
		too_long_d = too_long_q;
		hdr_err_d  = hdr_err_q;
		crc_d      = crc_q;
		gen_d      = gen_q;
		len_d      = len_q;
		trailer_d  = trailer_q;
		if (count_q >= MAX_CNT) begin
			too_long_d = 1'b1;
		end else begin
			if (count_q < CNT_W'(MAGIC_END)) begin
				if (data_byte != magic_byte && hdr_err_q == 3'd0) begin
					hdr_err_d = ST_MAGIC[2:0];
				end
			end else if (count_q == CNT_W'(VER_POS)) begin
				if (data_byte != VERSION_ONE && hdr_err_q == 3'd0) begin
					hdr_err_d = ST_VERSION[2:0];
				end
			end else if (count_q < CNT_W'(RSV_END)) begin
				if (data_byte != 8'd0 && hdr_err_q == 3'd0) begin
					hdr_err_d = ST_RESERVED[2:0];
				end
			end else if (count_q < CNT_W'(GEN_END)) begin
				gen_d = {gen_q[55:0], data_byte};
			end else if (count_q < CNT_W'(HDR_BYTES)) begin
				len_d = {len_q[23:0], data_byte};
			end
			// The four newest bytes are held back as a candidate trailer.
			if (count_q >= CNT_W'(TRL_BYTES)) begin
				crc_d = crc_byte(crc_q, trailer_q[31:24]);
			end
			trailer_d = {trailer_q[23:0], data_byte};
			count_d   = count_q + CNT_W'(1);
		end
	end

	assign len_sum   = {1'b0, len_d} + 33'(HDR_BYTES + TRL_BYTES);
	assign crc_final = ~crc_d;

	always_comb begin
		priority if (too_long_d) begin
			status = ST_TOO_LONG;
		end else if (count_d < CNT_W'(HDR_BYTES + TRL_BYTES)) begin
			status = ST_SHORT;
		end else if (hdr_err_d != 3'd0) begin
			status = {1'b0, hdr_err_d};
		end else if (gen_d == 64'd0) begin
			status = ST_ZERO_GEN;
		end else if (len_sum != 33'(count_d)) begin
			status = ST_LENGTH;
		end else if (crc_final != trailer_d) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		result.status       = status;
		result.record_valid = (status == ST_OK);
		result.generation   = (status == ST_OK) ? gen_d : 64'd0;
		result.body_len     = (status == ST_OK) ? len_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			too_long_q <= 1'b0;
			hdr_err_q  <= 3'd0;
			crc_q      <= CRC_INIT;
			gen_q      <= 64'd0;
			len_q      <= 32'd0;
			trailer_q  <= 32'd0;
		end else if (step) begin
			if (last_byte) begin
				count_q    <= '0;
				too_long_q <= 1'b0;
				hdr_err_q  <= 3'd0;
				crc_q      <= CRC_INIT;
				gen_q      <= 64'd0;
				len_q      <= 32'd0;
				trailer_q  <= 32'd0;
			end else begin
				count_q    <= count_d;
				too_long_q <= too_long_d;
				hdr_err_q  <= hdr_err_d;
				crc_q      <= crc_d;
				gen_q      <= gen_d;
				len_q      <= len_d;
				trailer_q  <= trailer_d;
			end
		end
	end

endmodule

// ===== rtl/slot_record_validator.sv =====
// Top level of the slot record validator: input stage, record checker and result register.
// Path: a final byte waits in the input stage until the checker absorbs it, and its verdict is
// registered in the result register as that byte is absorbed, then offered on the verdict stream.
// Throughput: one byte per cycle, set by the CRC byte update; a final byte waits in
// the input stage while the result register still holds a verdict that has not been taken.
// Reset: arst_n clears all record state, the magic register and both valid flags at once.
module slot_record_validator #(
	parameter int MAX_RECORD_BYTES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Magic word register write port.
	input  logic                     cfg_we,
	input  logic [31:0]              cfg_wdata,
	// Record byte stream.
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [srv_pkg::IN_W-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic                     s_axis_tlast,   // last_byte
	// Verdict stream, one transaction per record.
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [srv_pkg::OUT_W-1:0] m_axis_tdata   // [0] record_valid, [4:1] status,
	                                                 // [68:5] generation, [100:69] body_len,
	                                                 // [103:101] zero
);
	import srv_pkg::*;

	logic [31:0] magic_word_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	result_t     out_q;
	result_t     result;
	logic        out_free;
	logic        advance;

	// The magic register is written whenever the enable is high; no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= 32'd0;
		end else if (cfg_we) begin
			magic_word_q <= cfg_wdata;
		end
	end

	// The output slot can take a verdict if it is empty or being drained this cycle.
	assign out_free = !out_valid_q || m_axis_tready;

	// Only a final byte needs room in the output slot; all other bytes move on at once.
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// Input stage: holds one accepted byte until the checker absorbs it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	srv_core #(
		.MAX_RECORD_BYTES(MAX_RECORD_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.magic_word (magic_word_q),
		.result     (result)
	);

	// Result register: loaded by the final byte of a record, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	// A verdict is valid exactly when its status says the record passed.
	a_valid_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.record_valid == (out_q.status == ST_OK)))
		else $error("record_valid disagrees with status");

	// A rejected record never exposes header fields.
	a_reject_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.record_valid) |->
		(out_q.generation == 64'd0 && out_q.body_len == 32'd0))
		else $error("rejected record carries header fields");

	// A byte that is not the final one never waits in the input stage.
	a_mid_byte_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> advance)
		else $error("mid-record byte stalled");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.status <= ST_TOO_LONG))
		else $error("status code out of range");

endmodule
